// ----- rtl/hslp_pkg.sv -----
`default_nettype none
package hslp_pkg;

	localparam int MAX_PAYLOAD = 2048;
	localparam int POS_W = $clog2(MAX_PAYLOAD);
	localparam int CNT_W = POS_W + 1;
	localparam int LEN_W = 12;
	localparam int NUM_METH = 9;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_REQ,
		KIND_RESP,
		KIND_LONG
	} kind_t;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;

	// Texts are left aligned in eight characters; only the first METH_LEN chars count.
	localparam logic [63:0] METH_STR [NUM_METH] = '{
		"GET     ", "POST    ", "PUT     ", "HEAD    ", "OPTIONS ",
		"DELETE  ", "PATCH   ", "CONNECT ", "TRACE   "
	};
	localparam logic [3:0] METH_LEN [NUM_METH] = '{
		4'd4, 4'd5, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd8, 4'd6
	};
	localparam logic [63:0] HTTP_STR = "HTTP/1. ";
	localparam logic [2:0] HTTP_LEN = 3'd7;
	localparam logic [63:0] HOST_STR = "host:   ";
	localparam logic [2:0] HOST_LEN = 3'd5;

	// Tracking of the first line as it grows.
	typedef struct packed {
		logic [NUM_METH-1:0] cand;
		logic                http_c;
		logic                pe_found;
		logic                pe_bad;
		logic [POS_W-1:0]    pe;
		logic [2:0]          ver_cnt;
		logic                ver_ok;
		logic                ve_found;
		logic [POS_W-1:0]    ve;
		logic [1:0]          dig_cnt;
		logic                dig_ok;
		logic [9:0]          status;
		logic                rs_seen;
		logic                rsn_on;
		logic                rb_found;
		logic [POS_W-1:0]    rb;
		logic [LEN_W-1:0]    re;
	} trk_t;

	// Classification of a first line that would end at the current position.
	typedef struct packed {
		kind_t            kind;
		logic [3:0]       meth;
		logic [LEN_W-1:0] plen;
		logic [POS_W-1:0] voff;
		logic [LEN_W-1:0] vlen;
		logic [9:0]       stat;
		logic [POS_W-1:0] roff;
		logic [LEN_W-1:0] rlen;
	} vd_t;

	// Header line scan for the Host field.
	typedef struct packed {
		logic             on;
		logic             done;
		logic [2:0]       pos;
		logic             first_cr;
		logic             key_ok;
		logic             hb_found;
		logic [POS_W-1:0] hb;
		logic [LEN_W-1:0] he;
		logic             gap;
		logic             bad;
	} host_t;

	function automatic logic [7:0] char_at(input logic [63:0] s, input logic [2:0] k);
		return 8'(s >> {~k, 3'b000});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_tok(input logic [7:0] c);
		return is_alnum(c) || c == "-" || c == "_" || c == "." || c == "/" || c == CH_SP;
	endfunction

	function automatic logic is_hostc(input logic [7:0] c);
		return is_alnum(c) || c == "." || c == "-" || c == "_";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/http_start_line_parser_unit.sv -----
// Channel  Dir  Payload                                    Accepted when
// s_*      in   one payload byte, tlast on the final byte  s_tvalid && s_tready
// m_*      out  one classification per payload             m_tvalid && m_tready
//
// One byte is taken per clock; the per-byte work sits between the input stage
// and the state registers, so the sustained rate is one byte per cycle.
// A result is registered once its last byte leaves the input stage.
// Input stalls only while a last byte sits in the input stage, a finished result
// still waits in the output register and m_tready is low. Reset (arst_n low)
// empties both stages and starts a new payload.
`default_nettype none
module http_start_line_parser_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // data_byte
	input  wire logic         s_tlast,  // last_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_kind, method_code, path_offset, path_length, version_offset,
	// version_length, status_value, reason_offset, reason_length, host_offset,
	// host_length, zero fill
	output logic [111:0]      m_tdata
);
	import hslp_pkg::*;

	localparam trk_t TRK_INIT = '{cand: '1, http_c: 1'b1, ver_ok: 1'b1, dig_ok: 1'b1,
		default: '0};

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             adv;

	logic [CNT_W-1:0] cnt_q;
	logic [23:0]      hist_q;
	trk_t             trk_q, trk_n;
	vd_t              prev_vd_q, vd_cur;
	vd_t              lvd_q, lvd_n;
	logic             q0_found_q, q0_found_n;
	logic [POS_W-1:0] q0_q, q0_n;
	logic             q0_cr_q, q0_cr_n;
	logic             crlf_found_q, crlf_found_n;
	logic [POS_W-1:0] crlf_q, crlf_n;
	logic             lf_found_q, lf_found_n;
	logic [POS_W-1:0] lf_q, lf_n;
	host_t            host_q, host_n;
	logic [POS_W-1:0] hoff_q, hoff_n;
	logic [LEN_W-1:0] hlen_q, hlen_n;
	logic             out_vld_q;
	logic [111:0]     out_q, res;

	function automatic vd_t verdict(input trk_t t, input logic [CNT_W-1:0] l);
		vd_t v;
		logic [3:0] mi;
		logic mm;
		v = '0;
		mi = '0;
		mm = 1'b0;
		for (int m = 0; m < NUM_METH; m++) begin
			if (t.cand[m] && l >= CNT_W'(METH_LEN[m])) begin
				mm = 1'b1;
				mi = 4'(m);
			end
		end
		if (mm) begin
			if (t.pe_found && !t.pe_bad && t.ver_cnt == HTTP_LEN && t.ver_ok) begin
				v.kind = KIND_REQ;
				v.meth = mi;
				v.plen = LEN_W'(t.pe) - LEN_W'(METH_LEN[mi]);
				v.voff = t.pe + POS_W'(1);
				v.vlen = LEN_W'(l) - LEN_W'(t.pe) - LEN_W'(1);
			end
		end else if (t.http_c && l >= CNT_W'(HTTP_LEN) && t.ve_found
				&& t.dig_cnt == 2'd3 && t.dig_ok) begin
			v.kind = KIND_RESP;
			v.vlen = LEN_W'(t.ve);
			v.stat = t.status;
			if (t.rsn_on && t.rb_found) begin
				v.roff = t.rb;
				v.rlen = t.re - LEN_W'(t.rb);
			end
		end
		return v;
	endfunction

	assign adv = vld_s1 && (!last_s1 || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Per-byte update of all scanners.
	always_comb begin
		logic [POS_W-1:0] l;
		logic [7:0]       d;
		logic             run;
		logic             mm;
		logic [3:0]       ps;
		logic             hm;
		logic             empty;
		l = cnt_q[POS_W-1:0];
		d = byte_s1;
		run = cnt_q != CNT_W'(MAX_PAYLOAD);
		vd_cur = verdict(trk_q, cnt_q);
		trk_n = trk_q;
		lvd_n = lvd_q;
		q0_found_n = q0_found_q;
		q0_n = q0_q;
		q0_cr_n = q0_cr_q;
		crlf_found_n = crlf_found_q;
		crlf_n = crlf_q;
		lf_found_n = lf_found_q;
		lf_n = lf_q;
		host_n = host_q;
		hoff_n = hoff_q;
		hlen_n = hlen_q;
		mm = 1'b0;
		ps = '0;
		for (int m = 0; m < NUM_METH; m++) begin
			if (trk_q.cand[m] && cnt_q >= CNT_W'(METH_LEN[m])) begin
				mm = 1'b1;
				ps = METH_LEN[m];
			end
		end
		hm = trk_q.http_c && cnt_q >= CNT_W'(HTTP_LEN);
		empty = host_q.pos == 3'd0 || (host_q.pos == 3'd1 && host_q.first_cr);
		if (run) begin
			for (int m = 0; m < NUM_METH; m++) begin
				if (cnt_q < CNT_W'(METH_LEN[m]))
					trk_n.cand[m] = trk_q.cand[m] && d == char_at(METH_STR[m], l[2:0]);
			end
			if (cnt_q < CNT_W'(HTTP_LEN))
				trk_n.http_c = trk_q.http_c && d == char_at(HTTP_STR, l[2:0]);

			if (mm && !trk_q.pe_found) begin
				if (d == CH_SP) begin
					trk_n.pe_found = 1'b1;
					trk_n.pe = l;
					trk_n.pe_bad = cnt_q == CNT_W'(ps);
				end
			end else if (mm) begin
				if (trk_q.ver_cnt < HTTP_LEN) begin
					trk_n.ver_cnt = trk_q.ver_cnt + 3'd1;
					trk_n.ver_ok = trk_q.ver_ok && d == char_at(HTTP_STR, trk_q.ver_cnt);
				end
				trk_n.ver_ok = trk_n.ver_ok && is_tok(d);
			end

			if (hm && !trk_q.ve_found) begin
				if (d == CH_SP) begin
					trk_n.ve_found = 1'b1;
					trk_n.ve = l;
				end
			end else if (hm) begin
				if (trk_q.dig_cnt != 2'd3) begin
					trk_n.dig_cnt = trk_q.dig_cnt + 2'd1;
					trk_n.dig_ok = trk_q.dig_ok && is_digit(d);
					trk_n.status = 10'((14'(trk_q.status) * 14'd10) + 14'(d[3:0]));
				end else if (!trk_q.rs_seen) begin
					trk_n.rs_seen = 1'b1;
					trk_n.rsn_on = d == CH_SP;
				end else if (trk_q.rsn_on && !is_blank(d)) begin
					if (!trk_q.rb_found)
						trk_n.rb = l;
					trk_n.rb_found = 1'b1;
					trk_n.re = LEN_W'(l) + LEN_W'(1);
				end
			end

			if (d == CH_LF && !crlf_found_q && hist_q == {CH_CR, CH_LF, CH_CR}) begin
				crlf_found_n = 1'b1;
				crlf_n = l - POS_W'(3);
			end
			if (d == CH_LF && !lf_found_q && hist_q[7:0] == CH_LF) begin
				lf_found_n = 1'b1;
				lf_n = l - POS_W'(1);
			end

			if (d == CH_LF && !q0_found_q) begin
				// The first line ends here; a CR just before it is not part of it.
				q0_found_n = 1'b1;
				q0_n = l;
				q0_cr_n = hist_q[7:0] == CH_CR;
				lvd_n = (hist_q[7:0] == CH_CR) ? prev_vd_q : vd_cur;
				host_n = '0;
				host_n.on = 1'b1;
			end else if (host_q.on && !host_q.done) begin
				if (d == CH_LF) begin
					if (empty) begin
						host_n.done = 1'b1;
					end else if (host_q.key_ok && host_q.pos == HOST_LEN) begin
						host_n.done = 1'b1;
						if (host_q.hb_found && !host_q.bad) begin
							hoff_n = host_q.hb;
							hlen_n = host_q.he - LEN_W'(host_q.hb);
						end
					end else begin
						host_n = '0;
						host_n.on = 1'b1;
					end
				end else if (host_q.pos < HOST_LEN) begin
					if (host_q.pos == 3'd0) begin
						host_n.first_cr = d == CH_CR;
						host_n.key_ok = to_lower(d) == char_at(HOST_STR, host_q.pos);
					end else begin
						host_n.key_ok = host_q.key_ok
							&& to_lower(d) == char_at(HOST_STR, host_q.pos);
					end
					host_n.pos = host_q.pos + 3'd1;
				end else if (host_q.key_ok) begin
					if (is_blank(d)) begin
						if (host_q.hb_found)
							host_n.gap = 1'b1;
					end else begin
						if (!host_q.hb_found) begin
							host_n.hb_found = 1'b1;
							host_n.hb = l;
						end else if (host_q.gap) begin
							host_n.bad = 1'b1;
						end
						if (!is_hostc(d))
							host_n.bad = 1'b1;
						host_n.he = LEN_W'(l) + LEN_W'(1);
						host_n.gap = 1'b0;
					end
				end
			end
		end
	end

	// Result of a payload whose last byte is in the input stage.
	always_comb begin
		vd_t              v;
		logic [POS_W-1:0] hl;
		logic [POS_W-1:0] ho;
		logic [LEN_W-1:0] hn;
		v = '0;
		ho = '0;
		hn = '0;
		hl = crlf_found_n ? crlf_n : lf_n;
		if (cnt_q == CNT_W'(MAX_PAYLOAD)) begin
			v.kind = KIND_LONG;
		end else if (crlf_found_n || lf_found_n) begin
			v = lvd_n;
			// Without CRLFCRLF the first line may end on the LF of the LFLF itself,
			// and then a trailing CR stays in the line.
			if (!crlf_found_n && q0_n == lf_n && q0_cr_n && v.kind == KIND_REQ)
				v = '0;
			if (v.kind == KIND_REQ && q0_n < hl) begin
				ho = hoff_n;
				hn = hlen_n;
			end
		end
		res = {4'b0000, hn, ho, v.rlen, v.roff, v.stat, v.vlen, v.voff, v.plen,
			POS_W'(v.kind == KIND_REQ ? METH_LEN[v.meth] : 4'd0), v.meth, v.kind};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hist_q <= '0;
			trk_q <= TRK_INIT;
			prev_vd_q <= '0;
			lvd_q <= '0;
			q0_found_q <= 1'b0;
			q0_q <= '0;
			q0_cr_q <= 1'b0;
			crlf_found_q <= 1'b0;
			crlf_q <= '0;
			lf_found_q <= 1'b0;
			lf_q <= '0;
			host_q <= '0;
			hoff_q <= '0;
			hlen_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q <= '0;
				hist_q <= '0;
				trk_q <= TRK_INIT;
				prev_vd_q <= '0;
				lvd_q <= '0;
				q0_found_q <= 1'b0;
				q0_q <= '0;
				q0_cr_q <= 1'b0;
				crlf_found_q <= 1'b0;
				crlf_q <= '0;
				lf_found_q <= 1'b0;
				lf_q <= '0;
				host_q <= '0;
				hoff_q <= '0;
				hlen_q <= '0;
			end else begin
				if (cnt_q != CNT_W'(MAX_PAYLOAD))
					cnt_q <= cnt_q + CNT_W'(1);
				hist_q <= {hist_q[15:0], byte_s1};
				trk_q <= trk_n;
				prev_vd_q <= vd_cur;
				lvd_q <= lvd_n;
				q0_found_q <= q0_found_n;
				q0_q <= q0_n;
				q0_cr_q <= q0_cr_n;
				crlf_found_q <= crlf_found_n;
				crlf_q <= crlf_n;
				lf_found_q <= lf_found_n;
				lf_q <= lf_n;
				host_q <= host_n;
				hoff_q <= hoff_n;
				hlen_q <= hlen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			out_q <= res;
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAYLOAD))
		else $error("byte count beyond limit");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> m_tvalid)
		else $error("last byte gave no result");

	a_long_bare: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == KIND_LONG |-> m_tdata[111:2] == '0)
		else $error("overflow result carries fields");

	a_host_only_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != KIND_REQ |-> m_tdata[107:85] == '0)
		else $error("host reported without a request");
`endif

endmodule
`default_nettype wire
